// File: rtl/rle_text_decoder_assert.svh
// assertion macros for the run-length text decoder
`ifndef RLE_TEXT_DECODER_ASSERT_SVH
`define RLE_TEXT_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RTD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtd same-cycle check failed");
`define RTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtd next-cycle check failed");
`else
`define RTD_ASSERT_SAME(label, ante, cons)
`define RTD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/rtd_pkg.sv
package rtd_pkg;

  localparam int BYTE_W        = 8;
  localparam int COUNT_W       = 24;
  localparam int PROD_W        = COUNT_W + 4;
  localparam int DEF_MAX_DIGITS = 7;

  localparam logic [BYTE_W-1:0]  DASH_CHAR = 8'h2D;
  localparam logic [BYTE_W-1:0]  ZERO_CHAR = 8'h30;
  localparam logic [BYTE_W-1:0]  NINE_CHAR = 8'h39;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [COUNT_W-1:0] repeat_count;
  } res_t;

endpackage

// File: rtl/rtd_stream_if.sv
interface rtd_in_if
  import rtd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rtd_out_if
  import rtd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [COUNT_W-1:0] repeat_count;

  modport source (output valid, output out_byte, output repeat_count, input ready);
  modport sink (input valid, input out_byte, input repeat_count, output ready);
endinterface

// File: rtl/rtd_in_stage.sv
module rtd_in_stage
  import rtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              take,
  output logic              held_valid,
  output logic [BYTE_W-1:0] held_byte
);

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

// File: rtl/rtd_core.sv
`include "rle_text_decoder_assert.svh"

module rtd_core
  import rtd_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              held_valid,
  input  logic [BYTE_W-1:0] held_byte,
  input  logic              out_free,
  output logic              take,
  output logic              res_valid,
  output res_t              res
);

  localparam int DC_W = $clog2(MAX_DIGITS + 1);

  logic               literal_flag_r, literal_flag_nxt;
  logic [COUNT_W-1:0] count_accum_r, count_accum_nxt;
  logic [DC_W-1:0]    digit_count_r, digit_count_nxt;
  logic [COUNT_W-1:0] literal_left_r, literal_left_nxt;

  logic               is_digit;
  logic               is_term;
  logic [PROD_W-1:0]  prod;
  logic [COUNT_W-1:0] acc_sat;
  logic               emit;

  assign is_digit = (held_byte inside {[ZERO_CHAR:NINE_CHAR]});

  // count * 10 + digit as shift-add
  assign prod = ({4'b0, count_accum_r} << 3) + ({4'b0, count_accum_r} << 1)
              + PROD_W'(held_byte - ZERO_CHAR);
  assign acc_sat = (prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_W-1:0];

  assign is_term = (literal_left_r == '0) && (held_byte != DASH_CHAR) && !is_digit;

  always_comb begin
    emit        = 1'b0;
    res         = '0;
    res.out_byte = held_byte;
    if (literal_left_r != '0) begin
      emit             = 1'b1;
      res.repeat_count = COUNT_W'(1);
    end else if (is_term && count_accum_r != '0) begin
      emit             = 1'b1;
      res.repeat_count = literal_flag_r ? COUNT_W'(1) : count_accum_r;
    end
  end

  assign res_valid = held_valid && emit;
  assign take      = held_valid && (out_free || !emit);

  always_comb begin
    literal_flag_nxt = literal_flag_r;
    count_accum_nxt  = count_accum_r;
    digit_count_nxt  = digit_count_r;
    literal_left_nxt = literal_left_r;
    if (take) begin
      if (literal_left_r != '0) begin
        literal_left_nxt = literal_left_r - COUNT_W'(1);
      end else if (held_byte == DASH_CHAR) begin
        literal_flag_nxt = 1'b1;
      end else if (is_digit) begin
        if (digit_count_r < DC_W'(MAX_DIGITS)) begin
          count_accum_nxt = acc_sat;
          digit_count_nxt = digit_count_r + DC_W'(1);
        end
      end else begin
        literal_flag_nxt = 1'b0;
        count_accum_nxt  = '0;
        digit_count_nxt  = '0;
        if (literal_flag_r && count_accum_r != '0) begin
          literal_left_nxt = count_accum_r - COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      literal_flag_r <= 1'b0;
      count_accum_r  <= '0;
      digit_count_r  <= '0;
      literal_left_r <= '0;
    end else begin
      literal_flag_r <= literal_flag_nxt;
      count_accum_r  <= count_accum_nxt;
      digit_count_r  <= digit_count_nxt;
      literal_left_r <= literal_left_nxt;
    end
  end

  `RTD_ASSERT_SAME(a_count_nonzero, res_valid, res.repeat_count != '0)
  `RTD_ASSERT_SAME(a_digits_bounded, 1'b1, digit_count_r <= DC_W'(MAX_DIGITS))
  `RTD_ASSERT_SAME(a_literal_pass, held_valid && literal_left_r != '0,
                   res_valid && res.repeat_count == COUNT_W'(1))
  `RTD_ASSERT_NEXT(a_term_clears, take && is_term,
                   count_accum_r == '0 && digit_count_r == '0 && !literal_flag_r)

endmodule

// File: rtl/rtd_out_stage.sv
module rtd_out_stage
  import rtd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  res_t               res,
  input  logic               take,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [COUNT_W-1:0] repeat_count
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;
  logic load;

  assign out_free = !valid_r || out_ready;
  assign load     = res_valid && take;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = res_r.out_byte;
  assign repeat_count = res_r.repeat_count;

endmodule

// File: rtl/rle_text_decoder.sv
// run-length text decoder
// in_stream: one encoded ascii byte per transaction (valid/ready)
// out_stream: decoded byte plus repeat_count per transaction (valid/ready)
// digits build a decimal count (first MAX_DIGITS digits kept, saturating
// at 24 bits); '-' marks a literal run; the next other byte ends the count.
// run mode emits that byte once with repeat_count = count; literal mode
// passes it and the next count-1 bytes through with repeat_count 1.
// a count of zero emits nothing.
// throughput: one byte per cycle unless the receiver stalls, set by the
// single decode step between the input register and the result register.
// a byte is held in the input register, decoded combinationally, and its
// result is loaded into the result register that drives out_stream.
// reset (rst_n low, synchronous) empties both registers and clears the
// count, digit count, literal flag and pending literal run.
// when the receiver stalls, the held result waits in the result register;
// bytes that give no result keep flowing, and a byte that gives one waits
// in the input register, after which in_stream.ready drops.
module rle_text_decoder
  import rtd_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic  clk,
  input  logic  rst_n,
  rtd_in_if.sink    in_stream,
  rtd_out_if.source out_stream
);

  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              take;
  logic              out_free;
  logic              res_valid;
  res_t              res;

  rtd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_stream.valid),
    .in_ready   (in_stream.ready),
    .in_byte    (in_stream.data_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  rtd_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  rtd_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res          (res),
    .take         (take),
    .out_free     (out_free),
    .out_valid    (out_stream.valid),
    .out_ready    (out_stream.ready),
    .out_byte     (out_stream.out_byte),
    .repeat_count (out_stream.repeat_count)
  );

endmodule
